### rtl/core/swss_pkg.sv
// Shared constants, types and a function for the spacey walk stationary solver.
package swss_pkg;
   localparam int MaxStates   = 8;
   localparam int IdxW        = $clog2(MaxStates);
   localparam int NW          = $clog2(MaxStates + 1);
   localparam int TensorDepth = MaxStates * MaxStates * MaxStates;
   localparam int TAddrW      = $clog2(TensorDepth);
   localparam int ProbW       = 17;
   localparam int VecW        = 32;
   localparam int SumW        = 35;
   localparam int QuotW       = 31;
   localparam logic [ProbW-1:0] OneQ16 = 17'd65536;
   localparam logic [VecW-1:0]  OneQ30 = 32'h4000_0000;

   localparam logic [MaxStates:0][VecW-1:0] UniformQ30 = {
      OneQ30 / 8, OneQ30 / 7, OneQ30 / 6, OneQ30 / 5,
      OneQ30 / 4, OneQ30 / 3, OneQ30 / 2, 32'd0, 32'd0
   };

   localparam logic [1:0] CsrStates    = 2'd0;
   localparam logic [1:0] CsrIterLimit = 2'd1;
   localparam logic [1:0] CsrTolerance = 2'd2;
   localparam logic [1:0] CsrBlend     = 2'd3;

   localparam logic OpWrite = 1'b0;
   localparam logic OpRun   = 1'b1;

   typedef struct packed {
      logic               start;
      logic [VecW-1:0]    dividend;
      logic [SumW-1:0]    divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [QuotW-1:0]   quotient;
   } div_rsp_type;

   function automatic logic [VecW-1:0] uniform_start(input logic [NW-1:0] n);
      logic [VecW-1:0] v;
      v = UniformQ30[n];
      return v;
   endfunction
endpackage

### rtl/core/swss_divider.sv
// Restoring divider forming floor(dividend * 2^30 / divisor), one bit a cycle.
module swss_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  swss_pkg::div_req_type req,
   output swss_pkg::div_rsp_type rsp
);
   import swss_pkg::*;

   logic [SumW:0]      rem_ff, rem_in;
   logic [QuotW-1:0]   quot_ff, quot_in;
   logic [4:0]         count_ff, count_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [SumW:0]      trial;
   logic               fits;

   always_comb begin
      fits     = rem_ff >= {1'b0, req.divisor};
      trial    = fits ? rem_ff - {1'b0, req.divisor} : rem_ff;
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (req.start) begin
         rem_in   = {4'd0, req.dividend};
         quot_in  = '0;
         count_in = 5'(QuotW - 1);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in  = {trial[SumW-1:0], 1'b0};
         quot_in = {quot_ff[QuotW-2:0], fits};
         if (count_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            count_in = count_ff - 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      quot_ff  <= quot_in;
      count_ff <= count_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quot_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("divider done without work");
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      busy_ff && count_ff != 5'd0 |=> busy_ff) else $error("divider stopped early");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("divider done held");
endmodule

### rtl/core/spacey_walk_stationary_solver.sv
// Top level of the spacey walk stationary solver.
// Write word: accepted with no result; the next word may follow at once.
// Run word: starts a run; each iteration does multiply-accumulate, blending, then
// normalising division of each element (each is zeroed instead if the sum is zero),
// then the stop check; then n result words, one per accepted cycle.
// Reset is synchronous: control and configuration to defaults, tensor memory unwritten.
module spacey_walk_stationary_solver (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // entry_index[8:0], entry_value[25:9]
   input  logic        req_tuser,   // opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // state_index, probability, iterations_used, converged
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import swss_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_XJ, ST_RD, ST_M1, ST_M2, ST_ACC, ST_YW,
      ST_B1, ST_B2, ST_B3, ST_NS, ST_NW, ST_CHK, ST_EMIT
   } state_type;

   state_type          state_ff;
   logic [3:0]         cfg_n_ff;
   logic [15:0]        cfg_limit_ff;
   logic [31:0]        cfg_tol_ff;
   logic [16:0]        cfg_w_ff;

   logic [ProbW-1:0]   tensor_mem [TensorDepth];
   logic [ProbW-1:0]   rdata_ff;

   logic [VecW-1:0]    x_ff [MaxStates];
   logic [VecW-1:0]    y_ff [MaxStates];
   logic [NW-1:0]      n_ff;
   logic [16:0]        w_ff;
   logic [IdxW-1:0]    i_ff, j_ff, k_ff;
   logic [VecW-1:0]    xj_ff, xk_ff;
   logic [33:0]        xx_ff;
   logic [50:0]        prod_ff;
   logic [56:0]        acc_ff;
   logic [48:0]        t1_ff, t2_ff;
   logic [SumW-1:0]    dist_ff, sum_ff;
   logic [15:0]        used_ff;
   logic               conv_ff;
   logic               rsp_valid_ff;

   div_req_type        div_req;
   div_rsp_type        div_rsp;

   logic               req_acc;
   logic [TAddrW-1:0]  rd_addr;
   logic [63:0]        xprod;
   logic [NW-1:0]      n_clamp;
   logic [16:0]        w_clamp;
   logic [NW-1:0]      last;
   logic               i_last, j_last, k_last;
   logic [49:0]        blend_sum;
   logic [VecW-1:0]    blended;
   logic [VecW-1:0]    ydiff;
   logic [VecW-1:0]    ysat;
   logic [ProbW:0]     p_raw;
   logic [ProbW-1:0]   p_out;
   logic [15:0]        used_next;

   assign req_tready = state_ff == ST_IDLE;
   assign req_acc    = req_tvalid && req_tready;
   assign rd_addr    = {i_ff, j_ff, k_ff};
   assign xprod      = xj_ff * xk_ff;
   assign last       = n_ff - NW'(1);
   assign i_last     = {1'b0, i_ff} == last;
   assign j_last     = {1'b0, j_ff} == last;
   assign k_last     = {1'b0, k_ff} == last;
   assign n_clamp    = cfg_n_ff < 4'd2 ? NW'(2) :
                       (cfg_n_ff > 4'(MaxStates) ? NW'(MaxStates) : NW'(cfg_n_ff));
   assign w_clamp    = cfg_w_ff > OneQ16 ? OneQ16 : cfg_w_ff;
   assign blend_sum  = {1'b0, t1_ff} + {1'b0, t2_ff};
   assign blended    = blend_sum[47:16];
   assign ydiff      = y_ff[i_ff] >= x_ff[i_ff] ? y_ff[i_ff] - x_ff[i_ff]
                                                : x_ff[i_ff] - y_ff[i_ff];
   assign ysat       = acc_ff[56:48] != '0 ? '1 : acc_ff[47:16];
   assign used_next  = used_ff + 16'd1;

   assign div_req.start    = state_ff == ST_NS && sum_ff != '0;
   assign div_req.dividend = y_ff[i_ff];
   assign div_req.divisor  = sum_ff;

   swss_divider u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   always_ff @(posedge clock) begin
      if (req_acc && req_tuser == OpWrite) begin
         tensor_mem[req_tdata[8:0]] <= req_tdata[25:9] > OneQ16 ? OneQ16 : req_tdata[25:9];
      end
      rdata_ff <= tensor_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_n_ff     <= 4'd4;
         cfg_limit_ff <= 16'd1000;
         cfg_tol_ff   <= 32'd1;
         cfg_w_ff     <= 17'd64881;
      end else if (csr_we) begin
         unique case (csr_index)
            CsrStates:    cfg_n_ff     <= csr_wdata[3:0];
            CsrIterLimit: cfg_limit_ff <= csr_wdata[15:0];
            CsrTolerance: cfg_tol_ff   <= csr_wdata;
            CsrBlend:     cfg_w_ff     <= csr_wdata[16:0];
            default:      cfg_n_ff     <= cfg_n_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
         n_ff         <= NW'(4);
         used_ff      <= '0;
         conv_ff      <= 1'b0;
         for (int m = 0; m < MaxStates; m++) begin
            x_ff[m] <= '0;
            y_ff[m] <= '0;
         end
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_acc && req_tuser == OpRun) begin
                  n_ff    <= n_clamp;
                  w_ff    <= w_clamp;
                  used_ff <= '0;
                  conv_ff <= 1'b0;
                  i_ff    <= '0;
                  j_ff    <= '0;
                  k_ff    <= '0;
                  acc_ff  <= '0;
                  for (int m = 0; m < MaxStates; m++) begin
                     x_ff[m] <= NW'(m) < n_clamp ? uniform_start(n_clamp) : '0;
                     y_ff[m] <= '0;
                  end
                  if (cfg_limit_ff == 16'd0) begin
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= ST_EMIT;
                  end else begin
                     state_ff <= ST_XJ;
                  end
               end
            end
            ST_XJ: begin
               xj_ff    <= x_ff[j_ff];
               state_ff <= ST_RD;
            end
            ST_RD: begin
               xk_ff    <= x_ff[k_ff];
               state_ff <= ST_M1;
            end
            ST_M1: begin
               xx_ff    <= xprod[63:30];
               state_ff <= ST_M2;
            end
            ST_M2: begin
               prod_ff  <= rdata_ff * xx_ff;
               state_ff <= ST_ACC;
            end
            ST_ACC: begin
               acc_ff <= acc_ff + 57'(prod_ff);
               if (!k_last) begin
                  k_ff     <= k_ff + 1'b1;
                  state_ff <= ST_RD;
               end else begin
                  k_ff <= '0;
                  if (!j_last) begin
                     j_ff     <= j_ff + 1'b1;
                     state_ff <= ST_XJ;
                  end else begin
                     state_ff <= ST_YW;
                  end
               end
            end
            ST_YW: begin
               y_ff[i_ff] <= ysat;
               acc_ff     <= '0;
               j_ff       <= '0;
               if (!i_last) begin
                  i_ff     <= i_ff + 1'b1;
                  state_ff <= ST_XJ;
               end else begin
                  i_ff     <= '0;
                  dist_ff  <= '0;
                  sum_ff   <= '0;
                  state_ff <= ST_B1;
               end
            end
            ST_B1: begin
               t1_ff    <= w_ff * y_ff[i_ff];
               state_ff <= ST_B2;
            end
            ST_B2: begin
               t2_ff    <= (OneQ16 - w_ff) * x_ff[i_ff];
               dist_ff  <= dist_ff + SumW'(ydiff);
               state_ff <= ST_B3;
            end
            ST_B3: begin
               y_ff[i_ff] <= blended;
               sum_ff     <= sum_ff + SumW'(blended);
               if (!i_last) begin
                  i_ff     <= i_ff + 1'b1;
                  state_ff <= ST_B1;
               end else begin
                  i_ff     <= '0;
                  state_ff <= ST_NS;
               end
            end
            ST_NS: begin
               if (sum_ff == '0) begin
                  x_ff[i_ff] <= '0;
                  if (!i_last) begin
                     i_ff <= i_ff + 1'b1;
                  end else begin
                     i_ff     <= '0;
                     state_ff <= ST_CHK;
                  end
               end else begin
                  state_ff <= ST_NW;
               end
            end
            ST_NW: begin
               if (div_rsp.done) begin
                  x_ff[i_ff] <= VecW'(div_rsp.quotient);
                  if (!i_last) begin
                     i_ff     <= i_ff + 1'b1;
                     state_ff <= ST_NS;
                  end else begin
                     i_ff     <= '0;
                     state_ff <= ST_CHK;
                  end
               end
            end
            ST_CHK: begin
               used_ff <= used_next;
               j_ff    <= '0;
               k_ff    <= '0;
               if (dist_ff < SumW'(cfg_tol_ff)) begin
                  conv_ff      <= 1'b1;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_EMIT;
               end else if (used_next == cfg_limit_ff) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_EMIT;
               end else begin
                  state_ff <= ST_XJ;
               end
            end
            ST_EMIT: begin
               if (rsp_tready) begin
                  if (i_last) begin
                     i_ff         <= '0;
                     rsp_valid_ff <= 1'b0;
                     state_ff     <= ST_IDLE;
                  end else begin
                     i_ff <= i_ff + 1'b1;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign p_raw      = x_ff[i_ff][31:14];
   assign p_out      = p_raw > {1'b0, OneQ16} ? OneQ16 : p_raw[ProbW-1:0];
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = i_last;
   assign rsp_tdata  = {3'd0, conv_ff, used_ff, p_out, i_ff};

   a_valid_in_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> state_ff == ST_EMIT) else $error("result outside emit");
   a_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !req_tready) else $error("accept while busy");
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> used_ff <= cfg_limit_ff) else $error("iteration count over limit");
   a_div_in_norm: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == ST_NW) else $error("division result unexpected");
endmodule
